[rtl/core/rau_pkg.sv]
// Shared constants and control types for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

   // Default word width of the operands
   localparam int WORD_BITS_DEF = 32;

   // Operation codes
   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_CMP = 3'd4;

   // Multiplier pass selects
   localparam logic [1:0] MUL_P1 = 2'd0;
   localparam logic [1:0] MUL_P2 = 2'd1;
   localparam logic [1:0] MUL_P3 = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_step;
      logic       combine;
      logic       gcd_step;
      logic       gcd_end;
      logic       shift_step;
      logic       div_init;
      logic       div_step;
      logic       out_load;
   } rau_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic gcd_done;
      logic cnt_zero;
   } rau_sts_type;

endpackage

`default_nettype wire

[rtl/core/rau_if.sv]
// Request and response channel interfaces of the rational arithmetic unit.
`default_nettype none

interface rau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [31:0] a_num;
   logic signed [31:0] a_den;
   logic signed [31:0] b_num;
   logic signed [31:0] b_den;

   modport source (output valid, output mode, output a_num, output a_den,
                   output b_num, output b_den, input ready);
   modport sink   (input valid, input mode, input a_num, input a_den,
                   input b_num, input b_den, output ready);
endinterface

interface rau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_num;
   logic [30:0]        result_den;
   logic               zero_den;
   logic               overflow;

   modport source (output valid, output result_num, output result_den,
                   output zero_den, output overflow, input ready);
   modport sink   (input valid, input result_num, input result_den,
                   input zero_den, input overflow, output ready);
endinterface

`default_nettype wire

[rtl/core/rau_datapath.sv]
// Datapath: operand magnitudes, shared multiplier, adder, binary gcd and dividers.
`default_nettype none

module rau_datapath #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  wire                       clock,
   input  wire rau_pkg::rau_cmd_type cmd,
   output rau_pkg::rau_sts_type      sts,
   input  wire [2:0]                 mode,
   input  wire signed [31:0]         a_num,
   input  wire signed [31:0]         a_den,
   input  wire signed [31:0]         b_num,
   input  wire signed [31:0]         b_den,
   output logic signed [31:0]        result_num,
   output logic [30:0]               result_den,
   output logic                      zero_den,
   output logic                      overflow
);

   localparam int MW = WORD_BITS + 1;       // operand magnitude width
   localparam int NW = 2 * WORD_BITS + 2;   // intermediate magnitude width
   localparam int CW = $clog2(NW + 1);
   localparam logic [NW-1:0] SIGN_MAG = NW'(1) << (WORD_BITS - 1);

   // magnitude of a field read as its low WORD_BITS bits, sign-extended
   function automatic logic [MW-1:0] mag_of(input logic [31:0] v);
      logic [MW-1:0] s;
      s = MW'(signed'(v[WORD_BITS-1:0]));
      return s[MW-1] ? (MW'(0) - s) : s;
   endfunction

   // operand registers
   logic [2:0]    mode_ff;
   logic          same_ff;
   logic [MW-1:0] anm_ff, adm_ff, bnm_ff, bdm_ff;
   logic          ans_ff, ads_ff, bns_ff, bds_ff;
   // products
   logic [NW-1:0] p1m_ff, p2m_ff, p3m_ff;
   logic          p1s_ff, p2s_ff, p3s_ff;
   // unreduced fraction
   logic [NW-1:0] nmag_ff, nmag_in, dmag_ff, dmag_in;
   logic          nneg_ff, nneg_in, dneg_ff, dneg_in;
   // gcd and divider
   logic [NW-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [NW-1:0] qn_ff, qn_in, qd_ff, qd_in, rn_ff, rn_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   // result register
   logic signed [31:0] rnum_ff;
   logic [30:0]        rden_ff;
   logic               rzero_ff, rovf_ff;

   // load transaction fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode;
         same_ff <= (a_den[WORD_BITS-1:0] == b_den[WORD_BITS-1:0]);
         anm_ff  <= mag_of(a_num);
         adm_ff  <= mag_of(a_den);
         bnm_ff  <= mag_of(b_num);
         bdm_ff  <= mag_of(b_den);
         ans_ff  <= a_num[WORD_BITS-1];
         ads_ff  <= a_den[WORD_BITS-1];
         bns_ff  <= b_num[WORD_BITS-1];
         bds_ff  <= b_den[WORD_BITS-1];
      end
   end

   // shared multiplier, one product per pass
   logic [MW-1:0] mx, my;
   logic          mxs, mys;
   logic [NW-1:0] prod;

   always_comb begin
      unique case (cmd.mul_step)
         rau_pkg::MUL_P1: begin
            mx  = anm_ff;
            mxs = ans_ff;
            my  = (mode_ff == rau_pkg::MODE_MUL) ? bnm_ff : bdm_ff;
            mys = (mode_ff == rau_pkg::MODE_MUL) ? bns_ff : bds_ff;
         end
         rau_pkg::MUL_P2: begin
            mx  = bnm_ff;
            mxs = bns_ff;
            my  = adm_ff;
            mys = ads_ff;
         end
         default: begin
            mx  = adm_ff;
            mxs = ads_ff;
            my  = (mode_ff == rau_pkg::MODE_DIV) ? bnm_ff : bdm_ff;
            mys = (mode_ff == rau_pkg::MODE_DIV) ? bns_ff : bds_ff;
         end
      endcase
      prod = NW'(mx) * NW'(my);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         unique case (cmd.mul_step)
            rau_pkg::MUL_P1: begin p1m_ff <= prod; p1s_ff <= mxs ^ mys; end
            rau_pkg::MUL_P2: begin p2m_ff <= prod; p2s_ff <= mxs ^ mys; end
            default:         begin p3m_ff <= prod; p3s_ff <= mxs ^ mys; end
         endcase
      end
   end

   // sign-magnitude combine of the two terms
   logic [NW-1:0] am, bm, sm, dm_c;
   logic          as_c, bs_c, ss, ds_c;
   logic          is_addsub;

   always_comb begin
      is_addsub = (mode_ff == rau_pkg::MODE_ADD) || (mode_ff == rau_pkg::MODE_SUB) ||
                  (mode_ff == rau_pkg::MODE_CMP);
      am = '0; as_c = 1'b0; bm = '0; bs_c = 1'b0; dm_c = NW'(1); ds_c = 1'b0;
      if (is_addsub && same_ff) begin
         am = NW'(anm_ff); as_c = ans_ff;
         bm = NW'(bnm_ff); bs_c = bns_ff ^ (mode_ff != rau_pkg::MODE_ADD);
         dm_c = NW'(adm_ff); ds_c = ads_ff;
      end else if (is_addsub) begin
         am = p1m_ff; as_c = p1s_ff;
         bm = p2m_ff; bs_c = p2s_ff ^ (mode_ff != rau_pkg::MODE_ADD);
         dm_c = p3m_ff; ds_c = p3s_ff;
      end else if ((mode_ff == rau_pkg::MODE_MUL) || (mode_ff == rau_pkg::MODE_DIV)) begin
         am = p1m_ff; as_c = p1s_ff;
         dm_c = p3m_ff; ds_c = p3s_ff;
      end
      if (as_c == bs_c) begin
         sm = am + bm; ss = as_c;
      end else if (am >= bm) begin
         sm = am - bm; ss = as_c;
      end else begin
         sm = bm - am; ss = bs_c;
      end
   end

   // gcd, shift-back and divider next state
   logic [NW:0] rn_sh, rd_sh;

   always_comb begin
      nmag_in = nmag_ff; nneg_in = nneg_ff; dmag_in = dmag_ff; dneg_in = dneg_ff;
      x_in = x_ff; y_in = y_ff; g_in = g_ff; cnt_in = cnt_ff;
      qn_in = qn_ff; qd_in = qd_ff; rn_in = rn_ff; rd_in = rd_ff;
      rn_sh = {rn_ff, qn_ff[NW-1]};
      rd_sh = {rd_ff, qd_ff[NW-1]};
      if (cmd.combine) begin
         // zero numerator becomes 0/1
         if (sm == '0) begin
            nmag_in = '0; nneg_in = 1'b0; dmag_in = NW'(1); dneg_in = 1'b0;
         end else begin
            nmag_in = sm; nneg_in = ss; dmag_in = dm_c; dneg_in = ds_c;
         end
         x_in   = (sm == '0) ? '0 : sm;
         y_in   = (sm == '0) ? NW'(1) : dm_c;
         cnt_in = '0;
      end else if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1; y_in = y_ff >> 1; cnt_in = cnt_ff + CW'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_in = x_ff - y_ff;
         end else begin
            y_in = y_ff - x_ff;
         end
      end else if (cmd.gcd_end) begin
         g_in = x_ff | y_ff;
      end else if (cmd.shift_step) begin
         g_in = g_ff << 1; cnt_in = cnt_ff - CW'(1);
      end else if (cmd.div_init) begin
         qn_in = nmag_ff; qd_in = dmag_ff; rn_in = '0; rd_in = '0;
         cnt_in = CW'(NW);
      end else if (cmd.div_step) begin
         // one restoring quotient bit per cycle for both divisions
         if (rn_sh >= {1'b0, g_ff}) begin
            rn_in = NW'(rn_sh - {1'b0, g_ff}); qn_in = {qn_ff[NW-2:0], 1'b1};
         end else begin
            rn_in = rn_sh[NW-1:0]; qn_in = {qn_ff[NW-2:0], 1'b0};
         end
         if (rd_sh >= {1'b0, g_ff}) begin
            rd_in = NW'(rd_sh - {1'b0, g_ff}); qd_in = {qd_ff[NW-2:0], 1'b1};
         end else begin
            rd_in = rd_sh[NW-1:0]; qd_in = {qd_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      nmag_ff <= nmag_in; nneg_ff <= nneg_in; dmag_ff <= dmag_in; dneg_ff <= dneg_in;
      x_ff <= x_in; y_ff <= y_in; g_ff <= g_in; cnt_ff <= cnt_in;
      qn_ff <= qn_in; qd_ff <= qd_in; rn_ff <= rn_in; rd_ff <= rd_in;
   end

   assign sts.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign sts.cnt_zero = (cnt_ff == '0);

   // final sign, overflow and wrap of the reduced fraction
   logic                 rneg, rovf;
   logic [NW-1:0]        vneg;
   logic [WORD_BITS-1:0] vw, dw;

   always_comb begin
      rneg = (qd_ff == '0) ? nneg_ff : (nneg_ff ^ dneg_ff);
      rovf = (rneg ? (qn_ff > SIGN_MAG) : (qn_ff >= SIGN_MAG)) || (qd_ff >= SIGN_MAG);
      vneg = rneg ? (NW'(0) - qn_ff) : qn_ff;
      vw   = vneg[WORD_BITS-1:0];
      dw   = qd_ff[WORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rnum_ff  <= 32'(signed'(vw));
         rden_ff  <= 31'(dw);
         rzero_ff <= (qd_ff == '0);
         rovf_ff  <= rovf;
      end
   end

   assign result_num = rnum_ff;
   assign result_den = rden_ff;
   assign zero_den   = rzero_ff;
   assign overflow   = rovf_ff;

endmodule

`default_nettype wire

[rtl/core/rau_ctrl.sv]
// Controller: sequences multiply, combine, gcd, divide and result handoff.
`default_nettype none

module rau_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output rau_pkg::rau_cmd_type      cmd,
   input  wire rau_pkg::rau_sts_type sts
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_COMB = 3'd2;
   localparam logic [2:0] ST_GCD  = 3'd3;
   localparam logic [2:0] ST_SHB  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = rau_pkg::MUL_P1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = step_ff;
            if (step_ff == rau_pkg::MUL_P3) begin
               state_in = ST_COMB;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_COMB: begin
            cmd.combine = 1'b1;
            state_in    = ST_GCD;
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               cmd.gcd_end = 1'b1;
               state_in    = ST_SHB;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_SHB: begin
            if (sts.cnt_zero) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         ST_DIV: begin
            if (sts.cnt_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // accepted transaction starts the multiply passes
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MUL))
      else $error("accepted transaction did not start multiply");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // finished division hands off
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && sts.cnt_zero) |=> (state_ff == ST_DONE))
      else $error("divider end not followed by handoff");

   // result load raises response valid
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

[rtl/core/rational_arith_unit_core.sv]
// Top level of the rational arithmetic unit: controller plus datapath.
//
//   Channel   Modport  Handshake      Payload
//   req_chan  sink     valid/ready    mode, a_num, a_den, b_num, b_den
//   rsp_chan  source   valid/ready    result_num, result_den, zero_den, overflow
//
// One transaction at a time. Steps per transaction: accept, 3 multiply
// passes, combine, binary gcd steps, gcd end, one shift per common factor
// of two, the bit-serial divider steps and the handoff; the gcd loop and
// the bit-serial divider set the total.
// Synchronous active-high reset clears the controller and response valid.
// A new request is taken while a finished result still waits in the output register.
`default_nettype none

module rational_arith_unit_core #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  wire      clock,
   input  wire      reset,
   rau_req_if.sink   req_chan,
   rau_rsp_if.source rsp_chan
);

   rau_pkg::rau_cmd_type cmd;
   rau_pkg::rau_sts_type sts;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rau_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .sts        (sts),
      .mode       (req_chan.mode),
      .a_num      (req_chan.a_num),
      .a_den      (req_chan.a_den),
      .b_num      (req_chan.b_num),
      .b_den      (req_chan.b_den),
      .result_num (rsp_chan.result_num),
      .result_den (rsp_chan.result_den),
      .zero_den   (rsp_chan.zero_den),
      .overflow   (rsp_chan.overflow)
   );

endmodule

`default_nettype wire
